// File: design/erdr_pkg.sv
// shared constants, types and constant tables for the euler rotation dead reckoning block
// holds the cordic arctangent table and the elaboration-time gain computation
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package erdr_pkg;

  localparam int VEL_WIDTH          = 16;
  localparam int ANGLE_FRAC_BITS    = 13;
  localparam int POS_WIDTH          = 48;
  localparam int ROTATOR_ITERATIONS = 16;

  localparam int ANGLE_W     = ANGLE_FRAC_BITS + 3;
  localparam int GUARD_BITS  = 8;
  // internal vector width: guard bits plus headroom for cordic growth over three turns
  localparam int VEC_W       = VEL_WIDTH + GUARD_BITS + 4;
  // angle accumulator in q30 with room for the unreduced input range
  localparam int ANGLE_Q     = 30;
  localparam int T_W         = ANGLE_Q + 4;
  localparam int ANGLE_SHIFT = ANGLE_Q - ANGLE_FRAC_BITS;
  localparam int T_EXT       = T_W - ANGLE_W - ANGLE_SHIFT;

  localparam logic signed [T_W-1:0] HALF_PI_Q30 = T_W'(1686629713);
  localparam int QUARTER_TURNS = 3;

  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W     = 32;

  // gain multiply: k in q30, split into two 15-bit halves
  localparam int GAIN_W    = 2 * 15;
  localparam int GAIN_HALF = GAIN_W / 2;
  localparam int GACC_W    = VEC_W + 2;

  localparam int ROT_CNT_W = $clog2((ROTATOR_ITERATIONS > GAIN_W) ?
                                    ROTATOR_ITERATIONS : GAIN_W);

  localparam int DELTA_W   = VEC_W + 1 - GUARD_BITS;
  localparam int POS_CNT_W = $clog2(POS_WIDTH);

  typedef enum logic [2:0] {
    ROT_IDLE,
    ROT_QUARTER,
    ROT_CORDIC,
    ROT_GAIN,
    ROT_DONE
  } rot_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROLL_GO,
    ST_ROLL,
    ST_PITCH_GO,
    ST_PITCH,
    ST_YAW_GO,
    ST_YAW,
    ST_ROUND,
    ST_ACCUM,
    ST_CLAMP,
    ST_OUT
  } top_state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic last;
    logic clamp;
  } acc_ctl_t;

  // atan(2^-i) rounded to q30
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    unique case (idx)
      5'd0:  val = 32'd843314857;
      5'd1:  val = 32'd497837829;
      5'd2:  val = 32'd263043837;
      5'd3:  val = 32'd133525159;
      5'd4:  val = 32'd67021687;
      5'd5:  val = 32'd33543516;
      5'd6:  val = 32'd16775851;
      5'd7:  val = 32'd8388437;
      5'd8:  val = 32'd4194283;
      5'd9:  val = 32'd2097149;
      5'd10: val = 32'd1048576;
      5'd11: val = 32'd524288;
      5'd12: val = 32'd262144;
      5'd13: val = 32'd131072;
      5'd14: val = 32'd65536;
      5'd15: val = 32'd32768;
      5'd16: val = 32'd16384;
      5'd17: val = 32'd8192;
      5'd18: val = 32'd4096;
      5'd19: val = 32'd2048;
      5'd20: val = 32'd1024;
      5'd21: val = 32'd512;
      5'd22: val = 32'd256;
      5'd23: val = 32'd128;
      5'd24: val = 32'd64;
      5'd25: val = 32'd32;
      5'd26: val = 32'd16;
      5'd27: val = 32'd8;
      5'd28: val = 32'd4;
      5'd29: val = 32'd2;
      5'd30: val = 32'd1;
      5'd31: val = 32'd0;
    endcase
    return val;
  endfunction

  // shift-and-subtract quotient, evaluated only while elaborating
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          j;
    quo = '0;
    rem = '0;
    for (j = 63; j >= 0; j--) begin
      rem = {rem[63:0], num[j]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[j] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cordic gain in q30: integer square root of the scaled product of step gains
  function automatic logic [GAIN_W-1:0] calc_gain();
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    int          i;
    int          s;
    p = 64'd1 << 30;
    for (i = 0; i < ROTATOR_ITERATIONS; i++) begin
      p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
    end
    n     = p << 30;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (s = 0; s < 32; s++) begin
      if (n >= res + bit_v) begin
        n   = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[GAIN_W-1:0];
  endfunction

  localparam logic [GAIN_W-1:0] GAIN_K = calc_gain();
  localparam logic signed [GACC_W-1:0] GAIN_RND = GACC_W'(1) << (GAIN_HALF - 1);

endpackage

`default_nettype wire

// File: design/erdr_rotator.sv
// shared cordic rotator: quarter-turn reduction, one micro-rotation per cycle,
// then a bit-serial multiply by the gain constant, one gain bit per cycle
// depends on erdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module erdr_rotator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [erdr_pkg::VEC_W-1:0]    a_i,
  input  logic signed [erdr_pkg::VEC_W-1:0]    b_i,
  input  logic signed [erdr_pkg::ANGLE_W-1:0]  angle_i,
  output logic                                 done_o,
  output logic signed [erdr_pkg::VEC_W-1:0]    a_o,
  output logic signed [erdr_pkg::VEC_W-1:0]    b_o
);

  localparam logic [erdr_pkg::ROT_CNT_W-1:0] QUARTER_LAST =
    erdr_pkg::ROT_CNT_W'(erdr_pkg::QUARTER_TURNS - 1);
  localparam logic [erdr_pkg::ROT_CNT_W-1:0] CORDIC_LAST =
    erdr_pkg::ROT_CNT_W'(erdr_pkg::ROTATOR_ITERATIONS - 1);
  localparam logic [erdr_pkg::ROT_CNT_W-1:0] GAIN_LAST =
    erdr_pkg::ROT_CNT_W'(erdr_pkg::GAIN_W - 1);
  localparam logic [erdr_pkg::ROT_CNT_W-1:0] GAIN_MID =
    erdr_pkg::ROT_CNT_W'(erdr_pkg::GAIN_HALF);

  erdr_pkg::rot_state_e state_q, state_d;

  logic [erdr_pkg::ROT_CNT_W-1:0]     cnt_q, cnt_d;
  logic signed [erdr_pkg::VEC_W-1:0]  a_q, a_d, b_q, b_d;
  logic signed [erdr_pkg::T_W-1:0]    t_q, t_d;
  logic [erdr_pkg::GAIN_W-1:0]        k_q, k_d;
  logic signed [erdr_pkg::GACC_W-1:0] ga_q, ga_d, gb_q, gb_d;

  logic signed [erdr_pkg::VEC_W-1:0]  sa, sb;
  logic signed [erdr_pkg::T_W-1:0]    atan_v;
  logic signed [erdr_pkg::T_W-1:0]    angle_ext;
  logic signed [erdr_pkg::GACC_W-1:0] ga_add, gb_add, rnd_add, ga_sum, gb_sum;

  assign sa     = a_q >>> cnt_q;
  assign sb     = b_q >>> cnt_q;
  assign atan_v = {{(erdr_pkg::T_W - erdr_pkg::ATAN_W){1'b0}},
                   erdr_pkg::atan_q30(erdr_pkg::ATAN_IDX_W'(cnt_q))};
  assign angle_ext = {{erdr_pkg::T_EXT{angle_i[erdr_pkg::ANGLE_W-1]}}, angle_i,
                      {erdr_pkg::ANGLE_SHIFT{1'b0}}};

  // right-shifting accumulator: after all gain bits it holds the rounded product
  assign ga_add  = k_q[0] ? {{2{a_q[erdr_pkg::VEC_W-1]}}, a_q} : '0;
  assign gb_add  = k_q[0] ? {{2{b_q[erdr_pkg::VEC_W-1]}}, b_q} : '0;
  assign rnd_add = (cnt_q == GAIN_MID) ? erdr_pkg::GAIN_RND : '0;
  assign ga_sum  = ga_q + ga_add + rnd_add;
  assign gb_sum  = gb_q + gb_add + rnd_add;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      erdr_pkg::ROT_IDLE:    if (start_i) state_d = erdr_pkg::ROT_QUARTER;
      erdr_pkg::ROT_QUARTER: if (cnt_q == QUARTER_LAST) state_d = erdr_pkg::ROT_CORDIC;
      erdr_pkg::ROT_CORDIC:  if (cnt_q == CORDIC_LAST) state_d = erdr_pkg::ROT_GAIN;
      erdr_pkg::ROT_GAIN:    if (cnt_q == GAIN_LAST) state_d = erdr_pkg::ROT_DONE;
      erdr_pkg::ROT_DONE:    state_d = erdr_pkg::ROT_IDLE;
      default:               state_d = erdr_pkg::ROT_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d = cnt_q;
    a_d   = a_q;
    b_d   = b_q;
    t_d   = t_q;
    k_d   = k_q;
    ga_d  = ga_q;
    gb_d  = gb_q;
    unique case (state_q)
      erdr_pkg::ROT_IDLE: begin
        if (start_i) begin
          a_d   = a_i;
          b_d   = b_i;
          t_d   = angle_ext;
          cnt_d = '0;
        end
      end
      erdr_pkg::ROT_QUARTER: begin
        priority if (t_q > erdr_pkg::HALF_PI_Q30) begin
          a_d = -b_q;
          b_d = a_q;
          t_d = t_q - erdr_pkg::HALF_PI_Q30;
        end else if (t_q < -erdr_pkg::HALF_PI_Q30) begin
          a_d = b_q;
          b_d = -a_q;
          t_d = t_q + erdr_pkg::HALF_PI_Q30;
        end else begin
          // already within a quarter turn
        end
        cnt_d = (cnt_q == QUARTER_LAST) ? '0 : cnt_q + 1'b1;
      end
      erdr_pkg::ROT_CORDIC: begin
        if (!t_q[erdr_pkg::T_W-1]) begin
          a_d = a_q - sb;
          b_d = b_q + sa;
          t_d = t_q - atan_v;
        end else begin
          a_d = a_q + sb;
          b_d = b_q - sa;
          t_d = t_q + atan_v;
        end
        if (cnt_q == CORDIC_LAST) begin
          cnt_d = '0;
          k_d   = erdr_pkg::GAIN_K;
          ga_d  = '0;
          gb_d  = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      erdr_pkg::ROT_GAIN: begin
        ga_d  = ga_sum >>> 1;
        gb_d  = gb_sum >>> 1;
        k_d   = k_q >> 1;
        cnt_d = (cnt_q == GAIN_LAST) ? '0 : cnt_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erdr_pkg::ROT_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    t_q  <= t_d;
    k_q  <= k_d;
    ga_q <= ga_d;
    gb_q <= gb_d;
  end

  assign done_o = (state_q == erdr_pkg::ROT_DONE);
  assign a_o    = ga_q[erdr_pkg::VEC_W-1:0];
  assign b_o    = gb_q[erdr_pkg::VEC_W-1:0];

endmodule

`default_nettype wire

// File: design/erdr_accum.sv
// one position axis: rounds the rotated component and adds it to the stored
// position bit-serially, lsb first, then clamps on signed overflow
// depends on erdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module erdr_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  erdr_pkg::acc_ctl_t                  ctl_i,
  input  logic signed [erdr_pkg::VEC_W-1:0]   vec_i,
  output logic [erdr_pkg::POS_WIDTH-1:0]      pos_o
);

  localparam logic [erdr_pkg::POS_WIDTH-1:0] POS_MAX = {1'b0, {(erdr_pkg::POS_WIDTH-1){1'b1}}};
  localparam logic [erdr_pkg::POS_WIDTH-1:0] POS_MIN = {1'b1, {(erdr_pkg::POS_WIDTH-1){1'b0}}};
  localparam logic signed [erdr_pkg::VEC_W:0] ROUND_HALF =
    (erdr_pkg::VEC_W+1)'(1) << (erdr_pkg::GUARD_BITS - 1);

  logic [erdr_pkg::POS_WIDTH-1:0] pos_q, pos_d;
  logic [erdr_pkg::DELTA_W-1:0]   delta_q, delta_d;
  logic                           carry_q, carry_d;
  logic                           ovf_q, ovf_d;
  logic                           sign_q, sign_d;

  logic signed [erdr_pkg::VEC_W:0] rounded;
  logic                            sum_bit;

  assign rounded = {vec_i[erdr_pkg::VEC_W-1], vec_i} + ROUND_HALF;
  assign sum_bit = pos_q[0] ^ delta_q[0] ^ carry_q;

  always_comb begin
    pos_d   = pos_q;
    delta_d = delta_q;
    carry_d = carry_q;
    ovf_d   = ovf_q;
    sign_d  = sign_q;
    priority if (ctl_i.load) begin
      delta_d = rounded[erdr_pkg::VEC_W:erdr_pkg::GUARD_BITS];
      carry_d = 1'b0;
    end else if (ctl_i.shift) begin
      // position rotates through itself; delta shifts out with sign extension
      pos_d   = {sum_bit, pos_q[erdr_pkg::POS_WIDTH-1:1]};
      delta_d = {delta_q[erdr_pkg::DELTA_W-1], delta_q[erdr_pkg::DELTA_W-1:1]};
      carry_d = (pos_q[0] & delta_q[0]) | (carry_q & (pos_q[0] ^ delta_q[0]));
      if (ctl_i.last) begin
        ovf_d  = (pos_q[0] == delta_q[0]) && (sum_bit != pos_q[0]);
        sign_d = pos_q[0];
      end
    end else if (ctl_i.clamp) begin
      if (ovf_q) pos_d = sign_q ? POS_MIN : POS_MAX;
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    carry_q <= carry_d;
    ovf_q   <= ovf_d;
    sign_q  <= sign_d;
  end

  assign pos_o = pos_q;

endmodule

`default_nettype wire

// File: design/euler_rotation_dead_reckoning.sv
// dead reckoning top level: roll, pitch and yaw turns on one shared cordic rotator,
// then a bit-serial saturating add into the three position axes
// each turn runs on the rotator: 3 quarter-turn checks, one micro-rotation per cycle
// and one gain bit per cycle; the position add takes one bit per cycle
// one request at a time; a new one is taken only after the result is loaded for output
// reset clears the position to zero and empties the output register
`timescale 1ns / 1ps
`default_nettype none

module euler_rotation_dead_reckoning (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [erdr_pkg::VEL_WIDTH-1:0]   vel_x_i,
  input  logic signed [erdr_pkg::VEL_WIDTH-1:0]   vel_y_i,
  input  logic signed [erdr_pkg::VEL_WIDTH-1:0]   vel_z_i,
  input  logic signed [erdr_pkg::ANGLE_W-1:0]     roll_angle_i,
  input  logic signed [erdr_pkg::ANGLE_W-1:0]     pitch_angle_i,
  input  logic signed [erdr_pkg::ANGLE_W-1:0]     yaw_angle_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [erdr_pkg::POS_WIDTH-1:0]   pos_x_out_o,
  output logic signed [erdr_pkg::POS_WIDTH-1:0]   pos_y_out_o,
  output logic signed [erdr_pkg::POS_WIDTH-1:0]   pos_z_out_o
);

  localparam int VEC_PAD = erdr_pkg::VEC_W - erdr_pkg::VEL_WIDTH - erdr_pkg::GUARD_BITS;
  localparam logic [erdr_pkg::POS_CNT_W-1:0] ACC_LAST =
    erdr_pkg::POS_CNT_W'(erdr_pkg::POS_WIDTH - 1);

  erdr_pkg::top_state_e state_q, state_d;

  logic [erdr_pkg::POS_CNT_W-1:0]      acc_cnt_q, acc_cnt_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [erdr_pkg::VEC_W-1:0]   x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [erdr_pkg::ANGLE_W-1:0] roll_q, pitch_q, yaw_q;
  logic [erdr_pkg::POS_WIDTH-1:0]      pos_x_out_q, pos_y_out_q, pos_z_out_q;

  logic                                in_accept;
  logic                                out_free;
  logic                                out_load;
  logic                                rot_start;
  logic                                rot_done;
  logic signed [erdr_pkg::VEC_W-1:0]   rot_a, rot_b, rot_a_res, rot_b_res;
  logic signed [erdr_pkg::ANGLE_W-1:0] rot_angle;
  erdr_pkg::acc_ctl_t                  acc_ctl;
  logic [erdr_pkg::POS_WIDTH-1:0]      pos_x, pos_y, pos_z;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      erdr_pkg::ST_IDLE:     if (in_valid_i) state_d = erdr_pkg::ST_ROLL_GO;
      erdr_pkg::ST_ROLL_GO:  state_d = erdr_pkg::ST_ROLL;
      erdr_pkg::ST_ROLL:     if (rot_done) state_d = erdr_pkg::ST_PITCH_GO;
      erdr_pkg::ST_PITCH_GO: state_d = erdr_pkg::ST_PITCH;
      erdr_pkg::ST_PITCH:    if (rot_done) state_d = erdr_pkg::ST_YAW_GO;
      erdr_pkg::ST_YAW_GO:   state_d = erdr_pkg::ST_YAW;
      erdr_pkg::ST_YAW:      if (rot_done) state_d = erdr_pkg::ST_ROUND;
      erdr_pkg::ST_ROUND:    state_d = erdr_pkg::ST_ACCUM;
      erdr_pkg::ST_ACCUM:    if (acc_cnt_q == ACC_LAST) state_d = erdr_pkg::ST_CLAMP;
      erdr_pkg::ST_CLAMP:    state_d = erdr_pkg::ST_OUT;
      erdr_pkg::ST_OUT:      if (out_free) state_d = erdr_pkg::ST_IDLE;
      default:               state_d = erdr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o    = (state_q != erdr_pkg::ST_IDLE);
    rot_start     = (state_q == erdr_pkg::ST_ROLL_GO) || (state_q == erdr_pkg::ST_PITCH_GO) ||
                    (state_q == erdr_pkg::ST_YAW_GO);
    acc_ctl.load  = (state_q == erdr_pkg::ST_ROUND);
    acc_ctl.shift = (state_q == erdr_pkg::ST_ACCUM);
    acc_ctl.last  = (state_q == erdr_pkg::ST_ACCUM) && (acc_cnt_q == ACC_LAST);
    acc_ctl.clamp = (state_q == erdr_pkg::ST_CLAMP);
    out_load      = (state_q == erdr_pkg::ST_OUT) && out_free;
    acc_cnt_d     = (state_q == erdr_pkg::ST_ACCUM) ? acc_cnt_q + 1'b1 : '0;
    out_valid_d   = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  // roll turns (y, z), pitch turns (z, x), yaw turns (x, y)
  always_comb begin
    unique case (state_q)
      erdr_pkg::ST_PITCH_GO: begin
        rot_a     = z_q;
        rot_b     = x_q;
        rot_angle = pitch_q;
      end
      erdr_pkg::ST_YAW_GO: begin
        rot_a     = x_q;
        rot_b     = y_q;
        rot_angle = yaw_q;
      end
      default: begin
        rot_a     = y_q;
        rot_b     = z_q;
        rot_angle = roll_q;
      end
    endcase
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (in_accept) begin
      x_d = {{VEC_PAD{vel_x_i[erdr_pkg::VEL_WIDTH-1]}}, vel_x_i, {erdr_pkg::GUARD_BITS{1'b0}}};
      y_d = {{VEC_PAD{vel_y_i[erdr_pkg::VEL_WIDTH-1]}}, vel_y_i, {erdr_pkg::GUARD_BITS{1'b0}}};
      z_d = {{VEC_PAD{vel_z_i[erdr_pkg::VEL_WIDTH-1]}}, vel_z_i, {erdr_pkg::GUARD_BITS{1'b0}}};
    end else if (rot_done) begin
      unique case (state_q)
        erdr_pkg::ST_ROLL: begin
          y_d = rot_a_res;
          z_d = rot_b_res;
        end
        erdr_pkg::ST_PITCH: begin
          z_d = rot_a_res;
          x_d = rot_b_res;
        end
        erdr_pkg::ST_YAW: begin
          x_d = rot_a_res;
          y_d = rot_b_res;
        end
        default: begin
        end
      endcase
    end
  end

  erdr_rotator u_rotator (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start),
    .a_i     (rot_a),
    .b_i     (rot_b),
    .angle_i (rot_angle),
    .done_o  (rot_done),
    .a_o     (rot_a_res),
    .b_o     (rot_b_res)
  );

  erdr_accum u_accum_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .vec_i  (x_q),
    .pos_o  (pos_x)
  );

  erdr_accum u_accum_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .vec_i  (y_q),
    .pos_o  (pos_y)
  );

  erdr_accum u_accum_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .vec_i  (z_q),
    .pos_o  (pos_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= erdr_pkg::ST_IDLE;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_cnt_q   <= acc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (in_accept) begin
      roll_q  <= roll_angle_i;
      pitch_q <= pitch_angle_i;
      yaw_q   <= yaw_angle_i;
    end
    if (out_load) begin
      pos_x_out_q <= pos_x;
      pos_y_out_q <= pos_y;
      pos_z_out_q <= pos_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_out_o = pos_x_out_q;
  assign pos_y_out_o = pos_y_out_q;
  assign pos_z_out_o = pos_z_out_q;

`ifndef NO_ASSERTIONS
  a_done_in_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_done |-> (state_q == erdr_pkg::ST_ROLL || state_q == erdr_pkg::ST_PITCH ||
                  state_q == erdr_pkg::ST_YAW))
    else $error("rotator finished outside a turn");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == erdr_pkg::ST_ROLL_GO)
    else $error("accepted request did not start the roll turn");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == erdr_pkg::ST_OUT)
    else $error("result shown without a finished accumulation");

  a_accum_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == erdr_pkg::ST_ROUND |=> acc_cnt_q == '0)
    else $error("bit counter not cleared before serial add");
`endif

endmodule

`default_nettype wire
